### rtl/core/bslu_pkg.sv
package bslu_pkg;

  // default depth of the map store, in map bytes
  localparam int unsigned MAP_BYTES_DEF = 1024;

  localparam logic [63:0] TAG_BASE   = 64'h0000_0000_0012_3456;
  localparam logic [63:0] TAG_MAP    = TAG_BASE + 64'd1;
  localparam logic [63:0] TAG_COMP_A = TAG_BASE + 64'd2;
  localparam logic [63:0] TAG_COMP_B = TAG_BASE + 64'd3;

  typedef enum logic [3:0] {
    PH_TAG,
    PH_REG_ADDR,
    PH_REG_SIZE,
    PH_MAP,
    PH_SEEK_RD,
    PH_SEEK_CHK,
    PH_MAP_DATA,
    PH_RAW_ADDR,
    PH_RAW_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_RECORD = 2'd0,
    ST_END    = 2'd1,
    ST_COMP   = 2'd2,
    ST_LONG   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_MAP,
    SRC_RAW
  } src_t;

  // controller to datapath
  typedef struct packed {
    logic    take;
    logic    map_wr;
    logic    pos_clear;
    logic    ld_base;
    logic    ld_size;
    logic    ld_count;
    logic    ld_held;
    logic    dec_count;
    logic    seek_rd;
    logic    seek_hit;
    logic    seek_miss;
    logic    adv_bit;
    logic    emit;
    src_t    emit_src;
    status_t emit_status;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic word_done;
    logic word_zero;
    logic is_map_tag;
    logic is_comp_tag;
    logic size_long;
    logic size_zero;
    logic count_last;
    logic map_last;
    logic pos_end;
    logic hit;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/core/bslu_ctrl.sv
module bslu_ctrl import bslu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  input  dp_stat_t stat,
  output logic     byte_stall,
  output ctl_cmd_t cmd
);

  phase_t state;
  phase_t state_next;
  logic   acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_TAG;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit_src    = SRC_NONE;
    cmd.emit_status = ST_RECORD;

    unique case (state) inside
      PH_SEEK_RD, PH_SEEK_CHK: byte_stall = 1'b1;
      PH_DONE:                 byte_stall = 1'b0;
      default:                 byte_stall = !stat.out_free;
    endcase
    acc = byte_valid && !byte_stall;

    unique case (state)
      PH_TAG: begin
        if (acc) begin
          cmd.take = 1'b1;
          if (stat.word_done) begin
            if (stat.is_map_tag) begin
              state_next = PH_REG_ADDR;
            end else if (stat.is_comp_tag) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_COMP;
              state_next      = PH_DONE;
            end else if (stat.word_zero) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_END;
              state_next      = PH_DONE;
            end else begin
              cmd.ld_count = 1'b1;
              state_next   = PH_RAW_ADDR;
            end
          end
        end
      end
      PH_REG_ADDR: begin
        if (acc) begin
          cmd.take = 1'b1;
          if (stat.word_done) begin
            if (stat.word_zero) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_END;
              state_next      = PH_DONE;
            end else begin
              cmd.ld_base = 1'b1;
              state_next  = PH_REG_SIZE;
            end
          end
        end
      end
      PH_REG_SIZE: begin
        if (acc) begin
          cmd.take = 1'b1;
          if (stat.word_done) begin
            if (stat.size_long) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_LONG;
              state_next      = PH_DONE;
            end else begin
              cmd.ld_size = 1'b1;
              state_next  = stat.size_zero ? PH_REG_ADDR : PH_MAP;
            end
          end
        end
      end
      PH_MAP: begin
        if (acc) begin
          cmd.map_wr = 1'b1;
          if (stat.map_last) begin
            cmd.pos_clear = 1'b1;
            state_next    = PH_SEEK_RD;
          end
        end
      end
      PH_SEEK_RD: begin
        if (stat.pos_end) begin
          state_next = PH_REG_ADDR;
        end else begin
          cmd.seek_rd = 1'b1;
          state_next  = PH_SEEK_CHK;
        end
      end
      PH_SEEK_CHK: begin
        if (stat.hit) begin
          cmd.seek_hit = 1'b1;
          state_next   = PH_MAP_DATA;
        end else begin
          cmd.seek_miss = 1'b1;
          state_next    = PH_SEEK_RD;
        end
      end
      PH_MAP_DATA: begin
        if (acc) begin
          cmd.take = 1'b1;
          if (stat.word_done) begin
            cmd.emit     = 1'b1;
            cmd.emit_src = SRC_MAP;
            cmd.adv_bit  = 1'b1;
            state_next   = PH_SEEK_RD;
          end
        end
      end
      PH_RAW_ADDR: begin
        if (acc) begin
          cmd.take = 1'b1;
          if (stat.word_done) begin
            cmd.ld_held = 1'b1;
            state_next  = PH_RAW_DATA;
          end
        end
      end
      PH_RAW_DATA: begin
        if (acc) begin
          cmd.take = 1'b1;
          if (stat.word_done) begin
            cmd.emit      = 1'b1;
            cmd.emit_src  = SRC_RAW;
            cmd.dec_count = 1'b1;
            state_next    = stat.count_last ? PH_DONE : PH_RAW_ADDR;
          end
        end
      end
      PH_DONE: begin
        state_next = PH_DONE;
      end
      default: begin
        state_next = PH_DONE;
      end
    endcase
  end

endmodule

### rtl/core/bslu_dp.sv
module bslu_dp import bslu_pkg::*; #(
  parameter int unsigned MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  stream_byte,
  input  logic        load_stall,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    stat,
  output logic        load_valid,
  output logic [63:0] load_addr,
  output logic [63:0] load_data,
  output logic [1:0]  status
);

  localparam int unsigned POS_W = $clog2(MAP_BYTES + 1);
  localparam int unsigned IDX_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  logic [2:0]       byte_in_word;
  logic [63:0]      word_assembly;
  logic [63:0]      region_base;
  logic [POS_W-1:0] map_length;
  logic [POS_W-1:0] map_position;
  logic [2:0]       bit_position;
  logic [63:0]      records_left;
  logic [63:0]      held_address;
  logic [7:0]       map_store [MAP_BYTES];
  logic [7:0]       rd_byte;

  logic [63:0]      w_full;
  logic [57:0]      size_len;
  logic [7:0]       hit_mask;
  logic [2:0]       hit_idx;
  logic [63:0]      map_addr;

  // word completes on the eighth byte, first byte lands lowest
  assign w_full   = {stream_byte, word_assembly[63:8]};
  assign size_len = w_full[63:6];
  assign map_addr = region_base + 64'({map_position, bit_position, 3'b000});

  always_comb begin
    hit_mask = rd_byte & (8'hFF << bit_position);
    hit_idx  = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (hit_mask[i]) begin
        hit_idx = 3'(i);
      end
    end
  end

  always_comb begin
    stat.word_done   = (byte_in_word == 3'd7);
    stat.word_zero   = (w_full == 64'd0);
    stat.is_map_tag  = (w_full == TAG_MAP);
    stat.is_comp_tag = (w_full == TAG_COMP_A) || (w_full == TAG_COMP_B);
    stat.size_long   = (size_len > 58'(MAP_BYTES));
    stat.size_zero   = (size_len == 58'd0);
    stat.count_last  = (records_left == 64'd1);
    stat.map_last    = (POS_W'(map_position + 1'b1) == map_length);
    stat.pos_end     = (map_position >= map_length);
    stat.hit         = |hit_mask;
    stat.out_free    = !load_valid || !load_stall;
  end

  // map store, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.map_wr) begin
      map_store[map_position[IDX_W-1:0]] <= stream_byte;
    end
    if (cmd.seek_rd) begin
      rd_byte <= map_store[map_position[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_word <= 3'd0;
      map_position <= '0;
      bit_position <= 3'd0;
      map_length   <= '0;
    end else begin
      if (cmd.take) begin
        byte_in_word <= byte_in_word + 3'd1;
      end
      if (cmd.ld_size) begin
        map_length <= size_len[POS_W-1:0];
      end
      if (cmd.pos_clear || cmd.ld_size) begin
        map_position <= '0;
        bit_position <= 3'd0;
      end else if (cmd.map_wr || cmd.seek_miss) begin
        map_position <= map_position + 1'b1;
        bit_position <= 3'd0;
      end else if (cmd.seek_hit) begin
        bit_position <= hit_idx;
      end else if (cmd.adv_bit) begin
        bit_position <= bit_position + 3'd1;
        if (bit_position == 3'd7) begin
          map_position <= map_position + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      word_assembly <= w_full;
    end
    if (cmd.ld_base) begin
      region_base <= w_full;
    end
    if (cmd.ld_held) begin
      held_address <= w_full;
    end
    if (cmd.ld_count) begin
      records_left <= w_full;
    end else if (cmd.dec_count) begin
      records_left <= records_left - 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_valid <= 1'b0;
    end else if (cmd.emit) begin
      load_valid <= 1'b1;
    end else if (!load_stall) begin
      load_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status <= cmd.emit_status;
      case (cmd.emit_src)
        SRC_MAP: begin
          load_addr <= map_addr;
          load_data <= w_full;
        end
        SRC_RAW: begin
          load_addr <= held_address;
          load_data <= w_full;
        end
        default: begin
          load_addr <= 64'd0;
          load_data <= 64'd0;
        end
      endcase
    end
  end

endmodule

### rtl/core/bitmap_sparse_load_unpacker.sv
// latency: a result is registered and offered in the cycle after the byte that completes its word
// throughput: one stream byte per cycle reading words and map bytes, while the output is free
// after the map fill and after each data word the bit search reads the map store, a read
//   then a check step per map byte inspected, plus a read step when the region's map is used up
// reset (rst, synchronous, active high) returns to awaiting the format tag; the map
//   store is not cleared, entries are written before they are read
module bitmap_sparse_load_unpacker import bslu_pkg::*; #(
  parameter int unsigned MAP_BYTES = MAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // byte stream in, a transfer when byte_valid and not byte_stall
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  stream_byte,
  // load records out, a transfer when load_valid and not load_stall
  output logic        load_valid,
  input  logic        load_stall,
  output logic [63:0] load_addr,
  output logic [63:0] load_data,
  output logic [1:0]  status
);

  // command and status between sequencer and datapath
  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer: tag decode, region walk, map bit search and raw records
  bslu_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .stat       (stat),
    .byte_stall (byte_stall),
    .cmd        (cmd)
  );

  // datapath: word assembly, map store, address arithmetic and output register
  bslu_dp #(
    .MAP_BYTES (MAP_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .stream_byte (stream_byte),
    .load_stall  (load_stall),
    .cmd         (cmd),
    .stat        (stat),
    .load_valid  (load_valid),
    .load_addr   (load_addr),
    .load_data   (load_data),
    .status      (status)
  );

endmodule

### tb/sv/tb.sv
module tb;
  import bslu_pkg::*;

  // cycles with no transfer on either side before the run is abandoned; the bit search over a
  // full, empty map stays well within the limit, receiver stalls come on top
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  // quiet cycles after the last expected load, long enough for a full map search to finish
  localparam int unsigned DRAIN_CYCLES = 2200;
  // rough number of stream bytes in one run
  localparam int unsigned STREAM_BYTES = 1000;

  // decoder phases of the predictor
  typedef enum {
    UP_TAG,
    UP_BASE,
    UP_SIZE,
    UP_MAP,
    UP_DATA,
    UP_RAW_ADDR,
    UP_RAW_DATA,
    UP_DONE
  } unpack_phase_t;

  // how the map bytes of a generated region are filled
  typedef enum {
    FILL_ZERO,
    FILL_ONES,
    FILL_RANDOM,
    FILL_SPARSE,
    FILL_ENDS
  } map_fill_t;

  // stream format chosen for the run (one reset, so one format per run)
  typedef enum {
    FMT_MAP,
    FMT_RAW,
    FMT_RAW_OPEN,
    FMT_COMP,
    FMT_EMPTY
  } stream_fmt_t;

  typedef struct {
    logic [63:0] addr;
    logic [63:0] data;
    status_t     st;
  } load_rec_t;

  // decodes the accepted byte stream and checks the loads that come out
  class unpack_scoreboard;
    unpack_phase_t ph;
    logic [2:0]    byte_cnt;
    logic [63:0]   word_acc;
    logic [63:0]   region_base;
    int unsigned   map_len;
    logic [7:0]    map_mem [MAP_BYTES_DEF];
    int unsigned   map_pos;
    int unsigned   bit_pos;
    logic [63:0]   records_left;
    logic [63:0]   held_addr;
    load_rec_t     expected_loads [$];
    int            errors;

    function new();
      ph = UP_TAG;
      byte_cnt = '0;
      word_acc = '0;
      region_base = '0;
      map_len = 0;
      map_pos = 0;
      bit_pos = 0;
      records_left = '0;
      held_addr = '0;
      errors = 0;
    endfunction

    // next set map bit from the current position on, inclusive
    function bit seek_set_bit();
      while (map_pos < map_len) begin
        while (bit_pos < 8) begin
          if (map_mem[map_pos][bit_pos]) return 1'b1;
          bit_pos++;
        end
        bit_pos = 0;
        map_pos++;
      end
      return 1'b0;
    endfunction

    function void expect_load(logic [63:0] a, logic [63:0] d, status_t s);
      load_rec_t r;
      r.addr = a;
      r.data = d;
      r.st = s;
      expected_loads.insert(expected_loads.size(), r);
    endfunction

    function void note_stream_byte(logic [7:0] b);
      logic [63:0] w;
      logic [63:0] a;
      if (ph == UP_DONE) return;
      if (ph == UP_MAP) begin
        map_mem[map_pos] = b;
        map_pos++;
        if (map_pos >= map_len) begin
          map_pos = 0;
          bit_pos = 0;
          ph = seek_set_bit() ? UP_DATA : UP_BASE;
        end
        return;
      end
      word_acc = word_acc | ({56'd0, b} << (8 * byte_cnt));
      byte_cnt++;
      if (byte_cnt != 0) return;
      w = word_acc;
      word_acc = '0;
      case (ph)
        UP_TAG: begin
          if (w == TAG_MAP) begin
            ph = UP_BASE;
          end else if (w == TAG_COMP_A || w == TAG_COMP_B) begin
            ph = UP_DONE;
            expect_load('0, '0, ST_COMP);
          end else if (w == 0) begin
            ph = UP_DONE;
            expect_load('0, '0, ST_END);
          end else begin
            records_left = w;
            ph = UP_RAW_ADDR;
          end
        end
        UP_BASE: begin
          if (w == 0) begin
            ph = UP_DONE;
            expect_load('0, '0, ST_END);
          end else begin
            region_base = w;
            ph = UP_SIZE;
          end
        end
        UP_SIZE: begin
          if (w[63:6] > MAP_BYTES_DEF) begin
            ph = UP_DONE;
            expect_load('0, '0, ST_LONG);
          end else begin
            map_len = w[16:6];
            map_pos = 0;
            bit_pos = 0;
            ph = (map_len == 0) ? UP_BASE : UP_MAP;
          end
        end
        UP_DATA: begin
          a = region_base + 64'(map_pos) * 64 + 64'(bit_pos) * 8;
          bit_pos++;
          if (bit_pos >= 8) begin
            bit_pos = 0;
            map_pos++;
          end
          ph = seek_set_bit() ? UP_DATA : UP_BASE;
          expect_load(a, w, ST_RECORD);
        end
        UP_RAW_ADDR: begin
          held_addr = w;
          ph = UP_RAW_DATA;
        end
        UP_RAW_DATA: begin
          records_left--;
          ph = (records_left == 0) ? UP_DONE : UP_RAW_ADDR;
          expect_load(held_addr, w, ST_RECORD);
        end
        default: ph = UP_DONE;
      endcase
    endfunction

    function void check_load(logic [63:0] a, logic [63:0] d, logic [1:0] s);
      load_rec_t r;
      if (expected_loads.size() == 0) begin
        $display("%0t: load transfer with none expected, addr %h data %h status %0d",
                 $time, a, d, s);
        errors++;
        return;
      end
      r = expected_loads.pop_front();
      if (a !== r.addr) begin
        $display("%0t: load_addr expected %h actual %h", $time, r.addr, a);
        errors++;
      end
      if (d !== r.data) begin
        $display("%0t: load_data expected %h actual %h", $time, r.data, d);
        errors++;
      end
      if (s !== r.st) begin
        $display("%0t: status expected %0d actual %0d", $time, r.st, s);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  stream_byte = '0;
  logic        load_valid;
  logic        load_stall = 1'b0;
  logic [63:0] load_addr;
  logic [63:0] load_data;
  logic [1:0]  status;

  unpack_scoreboard sb = new();
  logic [7:0]       stream_q [$];
  int unsigned      rx_idle_pct = 55;
  int unsigned      quiet_cycles = 0;

  bitmap_sparse_load_unpacker dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .stream_byte(stream_byte),
    .load_valid (load_valid),
    .load_stall (load_stall),
    .load_addr  (load_addr),
    .load_data  (load_data),
    .status     (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // stream words go out little-endian, one byte per transfer
  function automatic void push_word(logic [63:0] w);
    for (int k = 0; k < 8; k++) stream_q.insert(stream_q.size(), w[8*k +: 8]);
  endfunction

  // data and address words, with the all-zero and all-one extremes now and then
  function automatic logic [63:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // a region base is never zero, zero would end the stream
  function automatic logic [63:0] rand_base();
    logic [63:0] w;
    w = rand_word();
    return (w == 0) ? 64'd1 : w;
  endfunction

  // mostly tiny maps, a few longer ones
  function automatic int unsigned rand_len();
    return ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(5);
  endfunction

  // base word, size word with random low bits below one map byte, the map, then one data
  // word per set map bit
  function automatic void push_region(logic [63:0] base, int unsigned len, map_fill_t fill);
    logic [7:0]  mb;
    int unsigned ones;
    ones = 0;
    push_word(base);
    push_word(64'(len) * 64 + 64'($urandom_range(63)));
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO:   mb = 8'h00;
        FILL_ONES:   mb = 8'hff;
        FILL_SPARSE: mb = ($urandom_range(3) == 0) ? 8'(1 << $urandom_range(7)) : 8'h00;
        FILL_ENDS:   mb = (i == 0) ? 8'h01 : (i == len - 1) ? 8'h80 : 8'h00;
        default:     mb = 8'($urandom);
      endcase
      stream_q.insert(stream_q.size(), mb);
      ones += $countones(mb);
    end
    repeat (ones) push_word(rand_word());
  endfunction

  function automatic void build_stream();
    int unsigned pick;
    int unsigned n;
    logic [63:0] w;
    pick = $urandom_range(19);
    if (pick < 12) n = FMT_MAP;
    else if (pick < 16) n = FMT_RAW;
    else if (pick < 18) n = FMT_RAW_OPEN;
    else if (pick == 18) n = FMT_COMP;
    else n = FMT_EMPTY;
    case (stream_fmt_t'(n))
      FMT_MAP: begin
        push_word(TAG_MAP);
        // directed regions: full map, empty map, clear map, wrapping addresses
        push_region(64'h1000, 2, FILL_ONES);
        push_region(rand_base(), 0, FILL_ZERO);
        push_region(rand_base(), 3, FILL_ZERO);
        push_region(64'hffff_ffff_ffff_fff8, 1, FILL_ONES);
        // the longest map in some runs only, it alone is about a thousand bytes
        if ($urandom_range(3) == 0) push_region('1, MAP_BYTES_DEF, FILL_ENDS);
        while (stream_q.size() < STREAM_BYTES)
          push_region(rand_base(), rand_len(), map_fill_t'($urandom_range(3)));
        // end with a zero base, an oversized map, or leave the stream open
        case ($urandom_range(2))
          0: push_word('0);
          1: begin
            push_word(rand_base());
            push_word($urandom_range(1) ? 64'(MAP_BYTES_DEF + 1) * 64 + 64'($urandom_range(63))
                                        : ({$urandom, $urandom} | (64'd1 << 63)));
          end
          default: ;
        endcase
      end
      FMT_RAW: begin
        n = ($urandom_range(4) == 0) ? 1 : $urandom_range(55, 62);
        push_word(64'(n));
        repeat (n) begin
          push_word(rand_word());
          push_word(rand_word());
        end
      end
      FMT_RAW_OPEN: begin
        // a count far larger than the records that follow, so the stream never ends
        w = $urandom_range(1) ? TAG_BASE : {$urandom, $urandom};
        if (w == TAG_MAP || w == TAG_COMP_A || w == TAG_COMP_B || w < 64'd100) w = TAG_BASE;
        push_word(w);
        repeat (62) begin
          push_word(rand_word());
          push_word(rand_word());
        end
      end
      FMT_COMP: push_word($urandom_range(1) ? TAG_COMP_A : TAG_COMP_B);
      default:  push_word('0);
    endcase
    // trailing bytes, ignored once the stream has finished, and padding up to the run length
    repeat ($urandom_range(8, 24)) stream_q.insert(stream_q.size(), 8'($urandom));
    while (stream_q.size() < STREAM_BYTES) stream_q.insert(stream_q.size(), 8'($urandom));
  endfunction

  // offer one byte, idling first at random, and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sb.note_stream_byte(b);
    @(negedge clk);
  endtask

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) load_stall <= ($urandom_range(99) < rx_idle_pct);

  // result checking and the watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst && load_valid && !load_stall) sb.check_load(load_addr, load_data, status);
    if (rst || (byte_valid && !byte_stall) || (load_valid && !load_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned total;
    int unsigned tx_pct;
    build_stream();
    total = stream_q.size();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // three idling phases by position in the stream: sender light and receiver heavy,
    // the other way round, then none at all
    for (int unsigned i = 0; i < total; i++) begin
      case (i * 3 / total)
        0: begin
          tx_pct = 29;
          rx_idle_pct = 55;
        end
        1: begin
          tx_pct = 55;
          rx_idle_pct = 29;
        end
        default: begin
          tx_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      send_byte(stream_q[i], tx_pct);
    end
    byte_valid <= 1'b0;
    while (sb.expected_loads.size() != 0) @(posedge clk);
    // catch any stray load after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### bitmap_sparse_load_unpacker.f
rtl/core/bslu_pkg.sv
rtl/core/bslu_ctrl.sv
rtl/core/bslu_dp.sv
rtl/core/bitmap_sparse_load_unpacker.sv
tb/sv/tb.sv
